### design/vtp_pkg.sv
package vtp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = 4;
    localparam int SUM_W       = 66;
    localparam int ROW_W       = SUM_W - FRAC_BITS;
    localparam int QUO_W       = 33;
    localparam int NUM_W       = ROW_W + FRAC_BITS;
    localparam int HI_W        = NUM_W - QUO_W;
    localparam int DIV_STEPS   = QUO_W;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_XFORM = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                        vld;
        logic                        divided;
        logic [2:0]                  neg;
        logic [2:0]                  ovf;
        logic [ROW_W-1:0]            den;
        logic [2:0][ROW_W-1:0]       rem;
        logic [2:0][QUO_W-1:0]       qn;
        logic [2:0][31:0]            sat;
    } t_div;

endpackage

### design/vtp_xform_front.sv
module vtp_xform_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_vld,
    input  vtp_pkg::t_cmd        i_cmd,
    input  logic [3:0]           i_idx,
    input  logic [31:0]          i_val,
    input  logic [2:0][31:0]     i_xyz,
    input  logic [30:0]          i_thr,
    output vtp_pkg::t_div        o_div
);
    import vtp_pkg::*;

    logic                          r_s0_vld;
    t_cmd                          r_s0_cmd;
    logic [IDX_W-1:0]              r_s0_idx;
    logic [31:0]                   r_s0_val;
    logic [2:0][31:0]              r_s0_xyz;
    logic [NUM_ENTRIES-1:0][31:0]  r_mat;

    logic                          r_s1_vld;
    logic signed [63:0]            r_s1_prod [4][3];
    logic [3:0][31:0]              r_s1_const;
    logic signed [63:0]            n_s1_prod [4][3];

    logic                          r_s2_vld;
    logic signed [SUM_W-1:0]       r_s2_sum [4];
    logic signed [SUM_W-1:0]       n_s2_sum [4];

    logic                          r_s3_vld;
    logic                          r_s3_div;
    logic [2:0]                    r_s3_neg;
    logic [2:0][ROW_W-1:0]         r_s3_abs;
    logic [ROW_W-1:0]              r_s3_den;
    logic [2:0][31:0]              r_s3_sat;
    logic                          n_s3_div;
    logic [2:0]                    n_s3_neg;
    logic [2:0][ROW_W-1:0]         n_s3_abs;
    logic [2:0][31:0]              n_s3_sat;
    logic signed [ROW_W-1:0]       w_row [4];

    t_div                          r_s4;
    t_div                          n_s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4.vld <= 1'b0;
            r_mat    <= '0;
        end else if (i_ce) begin
            r_s0_vld <= i_vld;
            r_s1_vld <= r_s0_vld && (r_s0_cmd == CMD_XFORM);
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4     <= n_s4;
            if (r_s0_vld && (r_s0_cmd == CMD_LOAD)) begin
                r_mat[r_s0_idx] <= r_s0_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s0_cmd   <= i_cmd;
            r_s0_idx   <= i_idx;
            r_s0_val   <= i_val;
            r_s0_xyz   <= i_xyz;
            r_s1_prod  <= n_s1_prod;
            r_s2_sum   <= n_s2_sum;
            r_s3_div   <= n_s3_div;
            r_s3_neg   <= n_s3_neg;
            r_s3_abs   <= n_s3_abs;
            r_s3_den   <= ROW_W'(w_row[3]);
            r_s3_sat   <= n_s3_sat;
            for (int r = 0; r < 4; r++) begin
                r_s1_const[r] <= r_mat[r*4+3];
            end
        end
    end

    // products
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_s1_prod[r][k] = $signed(r_mat[r*4+k]) * $signed(r_s0_xyz[k]);
            end
        end
    end

    // exact row sums
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_s2_sum[r] = SUM_W'(r_s1_prod[r][0]) + SUM_W'(r_s1_prod[r][1])
                        + SUM_W'(r_s1_prod[r][2])
                        + (SUM_W'($signed(r_s1_const[r])) <<< FRAC_BITS);
        end
    end

    // floor shift, threshold, magnitude, saturation
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_row[r] = $signed(r_s2_sum[r][SUM_W-1:FRAC_BITS]);
        end
        n_s3_div = w_row[3] > $signed({{(ROW_W-31){1'b0}}, i_thr});
        for (int k = 0; k < 3; k++) begin
            n_s3_neg[k] = w_row[k][ROW_W-1];
            n_s3_abs[k] = n_s3_neg[k] ? ROW_W'(-w_row[k]) : ROW_W'(w_row[k]);
            if (w_row[k] > $signed(ROW_W'(32'sh7FFF_FFFF))) begin
                n_s3_sat[k] = 32'h7FFF_FFFF;
            end else if (w_row[k] < $signed(ROW_W'(-64'sd2147483648))) begin
                n_s3_sat[k] = 32'h8000_0000;
            end else begin
                n_s3_sat[k] = w_row[k][31:0];
            end
        end
    end

    // divider setup
    always_comb begin
        logic [NUM_W-1:0] num;
        logic [HI_W-1:0]  hi;
        n_s4         = '0;
        n_s4.vld     = r_s3_vld;
        n_s4.divided = r_s3_div;
        n_s4.neg     = r_s3_neg;
        n_s4.den     = r_s3_den;
        n_s4.sat     = r_s3_sat;
        for (int k = 0; k < 3; k++) begin
            num            = {r_s3_abs[k], {FRAC_BITS{1'b0}}};
            hi             = num[NUM_W-1:QUO_W];
            n_s4.ovf[k]    = ROW_W'(hi) >= r_s3_den;
            n_s4.rem[k]    = n_s4.ovf[k] ? '0 : ROW_W'(hi);
            n_s4.qn[k]     = num[QUO_W-1:0];
        end
    end

    assign o_div = r_s4;

endmodule

### design/vtp_div_step.sv
module vtp_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  vtp_pkg::t_div  i_d,
    output vtp_pkg::t_div  o_q
);
    import vtp_pkg::*;

    t_div r_q;
    t_div n_q;

    always_comb begin
        logic [ROW_W:0] t;
        logic           ge;
        n_q = i_d;
        for (int k = 0; k < 3; k++) begin
            t           = {i_d.rem[k], i_d.qn[k][QUO_W-1]};
            ge          = t >= {1'b0, i_d.den};
            n_q.rem[k]  = ge ? ROW_W'(t - {1'b0, i_d.den}) : t[ROW_W-1:0];
            n_q.qn[k]   = {i_d.qn[k][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_ce) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### design/vertex_transform_perspective_divide_unit.sv
// Homogeneous 4x4 vertex transform with perspective divide, one transaction per
// clock unless the sink holds the output. A load transaction (tuser 0) writes one
// Q16.16 matrix entry and returns nothing; a transform transaction (tuser 1)
// returns x, y, z and a divided flag after passing the input register, 12 parallel
// 32x32 multipliers, row adders, threshold/saturation stage, divider setup, 33
// one-bit restoring divide stages shared by three lanes, and the output register.
// When the output is held by the sink the whole pipeline holds and s_axis_tready goes low.
module vertex_transform_perspective_divide_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [30:0]    i_cfg_wdata,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [135:0]   s_axis_tdata,  // entry_index, entry_value, x_in, y_in, z_in
    input  logic           s_axis_tuser,  // cmd
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [95:0]    m_axis_tdata,  // x_out, y_out, z_out
    output logic           m_axis_tuser   // divided
);
    import vtp_pkg::*;

    logic [30:0]        r_thr;
    logic               w_ce;
    t_div               w_chain [DIV_STEPS+1];
    logic [2:0][31:0]   w_xyz;
    logic               r_out_vld;
    logic [2:0][31:0]   r_out_data;
    logic               r_out_div;
    logic [2:0][31:0]   n_out_data;
    t_div               w_last;

    assign w_ce          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign w_xyz[0] = s_axis_tdata[67:36];
    assign w_xyz[1] = s_axis_tdata[99:68];
    assign w_xyz[2] = s_axis_tdata[131:100];

    vtp_xform_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_vld   (s_axis_tvalid),
        .i_cmd   (t_cmd'(s_axis_tuser)),
        .i_idx   (s_axis_tdata[3:0]),
        .i_val   (s_axis_tdata[35:4]),
        .i_xyz   (w_xyz),
        .i_thr   (r_thr),
        .o_div   (w_chain[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        vtp_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_d     (w_chain[g]),
            .o_q     (w_chain[g+1])
        );
    end

    assign w_last = w_chain[DIV_STEPS];

    always_comb begin
        logic [QUO_W-1:0] lim;
        logic [QUO_W-1:0] qs;
        for (int k = 0; k < 3; k++) begin
            lim = w_last.neg[k] ? QUO_W'(33'h0_8000_0000) : QUO_W'(33'h0_7FFF_FFFF);
            qs  = (w_last.ovf[k] || (w_last.qn[k] > lim)) ? lim : w_last.qn[k];
            if (!w_last.divided) begin
                n_out_data[k] = w_last.sat[k];
            end else if (w_last.neg[k]) begin
                n_out_data[k] = 32'd0 - qs[31:0];
            end else begin
                n_out_data[k] = qs[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_data <= n_out_data;
            r_out_div  <= w_last.divided;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_div;

    a_ready_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled while output not held");

    a_den_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last.vld && w_last.divided) |-> (w_last.den != '0))
        else $error("divide with zero divisor");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output transaction changed while held");

endmodule
